// ----- hdl/itp_pkg.sv -----
// ----------------------------------------------------------------------------
// itp_pkg: shared types and constants of the infix-to-postfix converter
// Stack geometry, operator codes, character constants, rank and code tables,
// and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package itp_pkg;

	// Operator stack geometry
	localparam int STACK_DEPTH = 32;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);

	// Stack entry codes
	localparam logic [2:0] CODE_LPAREN = 3'd0;
	localparam logic [2:0] CODE_PLUS   = 3'd1;
	localparam logic [2:0] CODE_MINUS  = 3'd2;
	localparam logic [2:0] CODE_TIMES  = 3'd3;
	localparam logic [2:0] CODE_DIVIDE = 3'd4;

	// ASCII characters with a special meaning
	localparam logic [7:0] CHAR_LPAREN = 8'h28;
	localparam logic [7:0] CHAR_RPAREN = 8'h29;
	localparam logic [7:0] CHAR_TIMES  = 8'h2A;
	localparam logic [7:0] CHAR_PLUS   = 8'h2B;
	localparam logic [7:0] CHAR_MINUS  = 8'h2D;
	localparam logic [7:0] CHAR_DIVIDE = 8'h2F;
	localparam logic [7:0] CHAR_NONE   = 8'h00;

	// Precedence of a stack code; '(' ranks lowest
	function automatic logic [1:0] code_rank(input logic [2:0] code);
		logic [1:0] rank;
		case (code)
			CODE_PLUS, CODE_MINUS:   rank = 2'd1;
			CODE_TIMES, CODE_DIVIDE: rank = 2'd2;
			default:                 rank = 2'd0;
		endcase
		return rank;
	endfunction

	// Character emitted for a popped stack code
	function automatic logic [7:0] code_char(input logic [2:0] code);
		logic [7:0] ch;
		case (code)
			CODE_PLUS:   ch = CHAR_PLUS;
			CODE_MINUS:  ch = CHAR_MINUS;
			CODE_TIMES:  ch = CHAR_TIMES;
			CODE_DIVIDE: ch = CHAR_DIVIDE;
			default:     ch = CHAR_LPAREN;
		endcase
		return ch;
	endfunction

	// Commands from controller to datapath
	typedef struct packed {
		logic take;        // latch the input item
		logic emit_char;   // emit the latched operand
		logic emit_pop;    // emit the top of stack
		logic emit_status; // emit the closing status result
		logic pop;         // drop the top of stack
		logic push;        // push the latched item's code
		logic set_err;     // flag an expression error
		logic clear_err;   // clear the error for the next expression
		logic run_last;    // result is the last one of its item
	} itp_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic       out_free;
		logic       cnt_zero;
		logic       cnt_one;
		logic       is_op;
		logic       is_lparen;
		logic       is_rparen;
		logic       item_last;
		logic [2:0] item_code;
		logic [2:0] top_code;
		logic [2:0] below_code;
	} itp_stat_t;

endpackage

// ----- hdl/infix_to_postfix_converter_core.sv -----
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_core: shunting-yard infix-to-postfix converter
// Each accepted item is latched into the item register first; its results are
//   then loaded into the output register one at a time, waiting while stalled.
// Input: a new item is taken only once the previous one is finished, with
//   the controller doing one stack step per cycle when the output is free.
// Reset: clears the controller state, stack count, error flag and output
//   valid at once; the stack memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_char,
	input  logic       is_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic       char_valid,
	output logic       run_last,
	output logic       expression_end,
	output logic       error
);
	import itp_pkg::*;

	itp_cmd_t  cmd;
	itp_stat_t stat;

	// Sequence the stack steps
	itp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Hold the stack and the output register
	itp_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_char        (in_char),
		.is_last        (is_last),
		.out_stall      (out_stall),
		.cmd            (cmd),
		.stat           (stat),
		.out_valid      (out_valid),
		.out_char       (out_char),
		.char_valid     (char_valid),
		.run_last       (run_last),
		.expression_end (expression_end),
		.error          (error)
	);

`ifndef NO_ASSERTIONS
	// One item at a time: an accepted item closes the input
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted while an item is still in work");

	// The status result closes its item and carries no character
	a_status_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && expression_end |-> run_last && !char_valid)
		else $error("status result malformed");

	// Character results carry no status flags
	a_char_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && char_valid |-> !error && !expression_end)
		else $error("character result carries status flags");

	// Never pop an empty stack for output
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_pop |-> !stat.cnt_zero)
		else $error("pop from an empty stack");
`endif

endmodule

// ----- hdl/itp_dp.sv -----
// ----------------------------------------------------------------------------
// itp_dp: converter datapath
// Item register, operator stack (cached top, prefetched entry below it, memory
// for the rest), stack count, sticky error flag and the output register.
// ----------------------------------------------------------------------------
module itp_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       in_char,
	input  logic             is_last,
	input  logic             out_stall,
	input  itp_pkg::itp_cmd_t  cmd,
	output itp_pkg::itp_stat_t stat,
	output logic             out_valid,
	output logic [7:0]       out_char,
	output logic             char_valid,
	output logic             run_last,
	output logic             expression_end,
	output logic             error
);
	import itp_pkg::*;

	logic [7:0]       char_q;
	logic             last_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_d;
	logic [2:0]       top_q;
	logic [2:0]       below_q;
	logic             err_q;
	logic [2:0]       stack_mem [STACK_DEPTH];

	logic             out_valid_q;
	logic [7:0]       out_char_q;
	logic             char_valid_q;
	logic             run_last_q;
	logic             end_q;
	logic             err_out_q;

	logic             full;
	logic             push_ok;
	logic             emit;
	logic [CNT_W-1:0] wr_cnt;
	logic [CNT_W-1:0] rd_cnt;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic [2:0]       item_code;
	logic             is_op;
	logic             is_lparen;
	logic             is_rparen;

	// Classify the latched character
	always_comb begin
		is_op     = 1'b0;
		is_lparen = 1'b0;
		is_rparen = 1'b0;
		item_code = CODE_LPAREN;
		case (char_q)
			CHAR_PLUS: begin
				is_op     = 1'b1;
				item_code = CODE_PLUS;
			end
			CHAR_MINUS: begin
				is_op     = 1'b1;
				item_code = CODE_MINUS;
			end
			CHAR_TIMES: begin
				is_op     = 1'b1;
				item_code = CODE_TIMES;
			end
			CHAR_DIVIDE: begin
				is_op     = 1'b1;
				item_code = CODE_DIVIDE;
			end
			CHAR_LPAREN: is_lparen = 1'b1;
			CHAR_RPAREN: is_rparen = 1'b1;
			default: ;
		endcase
	end

	// Next stack count and memory addresses
	assign full    = (cnt_q == CNT_W'(STACK_DEPTH));
	assign push_ok = cmd.push && !full;
	assign emit    = cmd.emit_char || cmd.emit_pop || cmd.emit_status;

	always_comb begin
		cnt_d = cnt_q;
		if (push_ok) begin
			cnt_d = cnt_q + CNT_W'(1);
		end else if (cmd.pop) begin
			cnt_d = cnt_q - CNT_W'(1);
		end
	end

	assign wr_cnt  = cnt_q - CNT_W'(1);
	assign rd_cnt  = cnt_d - CNT_W'(2);
	assign wr_addr = wr_cnt[ADDR_W-1:0];
	assign rd_addr = rd_cnt[ADDR_W-1:0];

	// Hold the latched item
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			char_q <= in_char;
			last_q <= is_last;
		end
	end

	// Advance the stack count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	// Spill the old top on push, refill it on pop, prefetch the entry below
	always_ff @(posedge clk) begin
		if (push_ok) begin
			if (cnt_q != '0) begin
				stack_mem[wr_addr] <= top_q;
			end
			top_q <= item_code;
		end else if (cmd.pop) begin
			top_q <= below_q;
		end
		if (push_ok && cnt_q != '0) begin
			below_q <= top_q;
		end else begin
			below_q <= stack_mem[rd_addr];
		end
	end

	// Track the sticky expression error
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q <= 1'b0;
		end else if (cmd.clear_err) begin
			err_q <= 1'b0;
		end else if (cmd.set_err || (cmd.push && full)) begin
			err_q <= 1'b1;
		end
	end

	// Load the output register, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (cmd.emit_char) begin
				out_char_q <= char_q;
			end else if (cmd.emit_pop) begin
				out_char_q <= code_char(top_q);
			end else begin
				out_char_q <= CHAR_NONE;
			end
			char_valid_q <= !cmd.emit_status;
			run_last_q   <= cmd.run_last;
			end_q        <= cmd.emit_status;
			err_out_q    <= cmd.emit_status && err_q;
		end
	end

	// Status toward the controller
	always_comb begin
		stat.out_free   = !out_valid_q || !out_stall;
		stat.cnt_zero   = (cnt_q == '0);
		stat.cnt_one    = (cnt_q == CNT_W'(1));
		stat.is_op      = is_op;
		stat.is_lparen  = is_lparen;
		stat.is_rparen  = is_rparen;
		stat.item_last  = last_q;
		stat.item_code  = item_code;
		stat.top_code   = top_q;
		stat.below_code = below_q;
	end

	assign out_valid      = out_valid_q;
	assign out_char       = out_char_q;
	assign char_valid     = char_valid_q;
	assign run_last       = run_last_q;
	assign expression_end = end_q;
	assign error          = err_out_q;

endmodule

// ----- hdl/itp_ctrl.sv -----
// ----------------------------------------------------------------------------
// itp_ctrl: converter controller
// Sequences one item at a time: latch, pop/emit/push steps, and the flush
// with its closing status result at the end of an expression.
// ----------------------------------------------------------------------------
module itp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  itp_pkg::itp_stat_t stat,
	output itp_pkg::itp_cmd_t  cmd
);
	import itp_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_EXEC  = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic [1:0] after_item;
	logic       op_pop;
	logic       op_stop_next;
	logic       rp_pop;
	logic       rp_stop_next;

	assign in_stall = (state_q != ST_IDLE);

	// Loop conditions for the operator and ')' pop runs
	assign op_pop       = !stat.cnt_zero &&
	                      (code_rank(stat.item_code) <= code_rank(stat.top_code));
	assign op_stop_next = stat.cnt_one ||
	                      (code_rank(stat.item_code) > code_rank(stat.below_code));
	assign rp_pop       = !stat.cnt_zero && (stat.top_code != CODE_LPAREN);
	assign rp_stop_next = stat.cnt_one || (stat.below_code == CODE_LPAREN);
	assign after_item   = stat.item_last ? ST_FLUSH : ST_IDLE;

	// Decide the step of this cycle
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (stat.is_op) begin
					if (op_pop) begin
						if (stat.out_free) begin
							cmd.emit_pop = 1'b1;
							cmd.pop      = 1'b1;
							cmd.run_last = !stat.item_last && op_stop_next;
						end
					end else begin
						cmd.push = 1'b1;
						state_d  = after_item;
					end
				end else if (stat.is_lparen) begin
					cmd.push = 1'b1;
					state_d  = after_item;
				end else if (stat.is_rparen) begin
					if (rp_pop) begin
						if (stat.out_free) begin
							cmd.emit_pop = 1'b1;
							cmd.pop      = 1'b1;
							cmd.run_last = !stat.item_last && rp_stop_next;
						end
					end else begin
						if (stat.cnt_zero) begin
							cmd.set_err = 1'b1;
						end else begin
							cmd.pop = 1'b1;
						end
						state_d = after_item;
					end
				end else if (stat.out_free) begin
					cmd.emit_char = 1'b1;
					cmd.run_last  = !stat.item_last;
					state_d       = after_item;
				end
			end
			ST_FLUSH: begin
				if (stat.out_free) begin
					if (!stat.cnt_zero) begin
						cmd.emit_pop = 1'b1;
						cmd.pop      = 1'b1;
						cmd.set_err  = (stat.top_code == CODE_LPAREN);
					end else begin
						cmd.emit_status = 1'b1;
						cmd.clear_err   = 1'b1;
						cmd.run_last    = 1'b1;
						state_d         = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Advance the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- verif/infix_to_postfix_converter_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_core_tb: self-checking bench for the converter
// Feeds infix characters through the valid/stall input channel and checks
// every postfix character and closing status item against typed results or
// a bench shunting-yard predictor. A short table of hand-picked characters
// comes first, then a stack overflow run, then random expressions: mostly
// well-formed, some broken, some noise, a few nested around the stack depth.
// Both channels idle at random; one long output hold-off backs up the block.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_core_tb;
	import itp_pkg::*;

	localparam int RANDOM_ITEMS = 390;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int DRAIN_CYCLES = 50;
	localparam int HOLD_CYCLES  = 400;
	localparam int HOLD_AFTER   = 80;

	// How a stimulus row is checked: by the predictor, a typed result or not at all
	typedef enum logic [2:0] {
		CHK_MODEL,
		CHK_NONE,
		CHK_ECHO,
		CHK_STATUS,
		CHK_ECHO_STATUS
	} row_check_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		row_check_t check;
		logic       err;
	} stim_item_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       cv;
		logic       rl;
		logic       eoe;
		logic       err;
	} postfix_result_t;

	// Receiver stall styles
	typedef enum logic [2:0] {
		RX_FREE,
		RX_LIGHT,
		RX_HEAVY,
		RX_TOGGLE,
		RX_HOLD
	} rx_mode_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] in_char = '0;
	logic       is_last = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_char;
	logic       char_valid;
	logic       run_last;
	logic       expression_end;
	logic       error;

	stim_item_t      stim_q[$];
	postfix_result_t expected_results[$];
	postfix_result_t step_results[$];
	postfix_result_t want;
	logic [7:0]      expr_buf[$];
	stim_item_t      intro_rows[24];

	// Predictor state
	logic [2:0] op_stack[STACK_DEPTH];
	int         op_depth = 0;
	logic       expr_err = 1'b0;

	int fail_count = 0;
	int items_taken = 0;
	int results_checked = 0;
	int exprs_closed = 0;
	int exprs_flagged = 0;
	int deepest = 0;
	int longest_run = 0;
	int cycle_count = 0;
	int burst_left = 0;
	int gap_left = 0;
	rx_mode_t rx_mode = RX_FREE;
	int rx_span = 16;
	bit long_hold_done = 1'b0;

	infix_to_postfix_converter_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_char        (in_char),
		.is_last        (is_last),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_char       (out_char),
		.char_valid     (char_valid),
		.run_last       (run_last),
		.expression_end (expression_end),
		.error          (error)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Precedence of a stacked code; '(' ranks below every operator
	function automatic int rank_of(logic [2:0] code);
		if (code == CODE_TIMES || code == CODE_DIVIDE)
			return 2;
		if (code == CODE_PLUS || code == CODE_MINUS)
			return 1;
		return 0;
	endfunction

	function automatic logic [7:0] symbol_of(logic [2:0] code);
		case (code)
			CODE_PLUS:   return CHAR_PLUS;
			CODE_MINUS:  return CHAR_MINUS;
			CODE_TIMES:  return CHAR_TIMES;
			CODE_DIVIDE: return CHAR_DIVIDE;
			default:     return CHAR_LPAREN;
		endcase
	endfunction

	// Pop the top entry and emit its character
	function automatic void emit_top();
		step_results.push_back('{symbol_of(op_stack[op_depth - 1]), 1'b1, 1'b0, 1'b0, 1'b0});
		op_depth--;
	endfunction

	// Push a code; a full stack drops it and flags the expression
	function automatic void push_op(logic [2:0] code);
		if (op_depth >= STACK_DEPTH) begin
			expr_err = 1'b1;
		end else begin
			op_stack[op_depth] = code;
			op_depth++;
			if (op_depth > deepest)
				deepest = op_depth;
		end
	endfunction

	// Work out the postfix items caused by one infix character
	function automatic void convert_char(logic [7:0] ch, logic last);
		logic [2:0] code;
		postfix_result_t tail;
		step_results.delete();
		case (ch)
			CHAR_PLUS:   code = CODE_PLUS;
			CHAR_MINUS:  code = CODE_MINUS;
			CHAR_TIMES:  code = CODE_TIMES;
			default:     code = CODE_DIVIDE;
		endcase
		if (ch inside {CHAR_PLUS, CHAR_MINUS, CHAR_TIMES, CHAR_DIVIDE}) begin
			while (op_depth > 0 && rank_of(code) <= rank_of(op_stack[op_depth - 1]))
				emit_top();
			push_op(code);
		end else if (ch == CHAR_LPAREN) begin
			push_op(CODE_LPAREN);
		end else if (ch == CHAR_RPAREN) begin
			while (op_depth > 0 && op_stack[op_depth - 1] != CODE_LPAREN)
				emit_top();
			if (op_depth > 0)
				op_depth--;
			else
				expr_err = 1'b1;
		end else begin
			step_results.push_back('{ch, 1'b1, 1'b0, 1'b0, 1'b0});
		end
		// Flush the stack and close the expression
		if (last) begin
			while (op_depth > 0) begin
				if (op_stack[op_depth - 1] == CODE_LPAREN)
					expr_err = 1'b1;
				emit_top();
			end
			step_results.push_back('{CHAR_NONE, 1'b0, 1'b0, 1'b1, expr_err});
			exprs_closed++;
			if (expr_err)
				exprs_flagged++;
			expr_err = 1'b0;
		end
		if (step_results.size() > 0) begin
			tail = step_results.pop_back();
			tail.rl = 1'b1;
			step_results.push_back(tail);
		end
		if (step_results.size() > longest_run)
			longest_run = step_results.size();
	endfunction

	// Accepted item: advance the predictor, queue typed or predicted results
	function automatic void take_item(stim_item_t it);
		convert_char(it.ch, it.last);
		case (it.check)
			CHK_MODEL: begin
				foreach (step_results[i])
					expected_results.push_back(step_results[i]);
			end
			CHK_ECHO: expected_results.push_back('{it.ch, 1'b1, 1'b1, 1'b0, 1'b0});
			CHK_STATUS: expected_results.push_back('{CHAR_NONE, 1'b0, 1'b1, 1'b1, it.err});
			CHK_ECHO_STATUS: begin
				expected_results.push_back('{it.ch, 1'b1, 1'b0, 1'b0, 1'b0});
				expected_results.push_back('{CHAR_NONE, 1'b0, 1'b1, 1'b1, it.err});
			end
			default: ;
		endcase
	endfunction

	function automatic void check_field(string name, int exp_val, int act_val);
		if (exp_val != act_val) begin
			$display("[%0t] %s mismatch: expected %0h, got %0h", $time, name, exp_val, act_val);
			fail_count++;
		end
	endfunction

	function automatic void queue_item(logic [7:0] ch, logic last);
		stim_q.push_back('{ch, last, CHK_MODEL, 1'b0});
	endfunction

	// Index 0-3 gives an operator, 4-5 a parenthesis
	function automatic logic [7:0] pick_symbol(int idx);
		case (idx)
			0:       return CHAR_PLUS;
			1:       return CHAR_MINUS;
			2:       return CHAR_TIMES;
			3:       return CHAR_DIVIDE;
			4:       return CHAR_LPAREN;
			default: return CHAR_RPAREN;
		endcase
	endfunction

	function automatic logic [7:0] random_operand();
		logic [7:0] ch;
		do
			ch = 8'($urandom_range(0, 255));
		while (ch inside {CHAR_PLUS, CHAR_MINUS, CHAR_TIMES, CHAR_DIVIDE,
			CHAR_LPAREN, CHAR_RPAREN});
		return ch;
	endfunction

	// Build a well-formed expression with random nesting into expr_buf
	function automatic void build_expression(int max_nest);
		int operands;
		int open;
		bit want_operand;
		operands = $urandom_range(1, 8);
		open = 0;
		want_operand = 1'b1;
		expr_buf.delete();
		forever begin
			if (want_operand) begin
				if (open < max_nest && $urandom_range(0, 3) == 0) begin
					expr_buf.push_back(CHAR_LPAREN);
					open++;
				end else begin
					expr_buf.push_back(random_operand());
					operands--;
					want_operand = 1'b0;
				end
			end else if (operands == 0) begin
				break;
			end else if (open > 0 && $urandom_range(0, 2) == 0) begin
				expr_buf.push_back(CHAR_RPAREN);
				open--;
			end else begin
				expr_buf.push_back(pick_symbol($urandom_range(0, 3)));
				want_operand = 1'b1;
			end
		end
		repeat (open)
			expr_buf.push_back(CHAR_RPAREN);
	endfunction

	function automatic void queue_expression();
		foreach (expr_buf[i])
			queue_item(expr_buf[i], i == expr_buf.size() - 1);
	endfunction

	// Sender: offer items in bursts with random gaps, hold while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_char <= '0;
			is_last <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (in_valid && !in_stall) begin
				take_item(stim_q.pop_front());
				items_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (stim_q.size() == 0) begin
					in_valid <= 1'b0;
				end else begin
					in_valid <= 1'b1;
					in_char <= stim_q[0].ch;
					is_last <= stim_q[0].last;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left--;
					end
				end
			end
		end
	end

	// Receiver: stall in stretches of random style; one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (!long_hold_done && items_taken >= HOLD_AFTER) begin
				rx_mode = RX_HOLD;
				rx_span = HOLD_CYCLES;
				long_hold_done = 1'b1;
			end else if (rx_span == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 4));
				rx_span = (rx_mode == RX_HOLD) ? $urandom_range(10, 60) : $urandom_range(20, 150);
			end else begin
				rx_span--;
			end
			case (rx_mode)
				RX_FREE:   out_stall <= 1'b0;
				RX_LIGHT:  out_stall <= ($urandom_range(0, 4) == 0);
				RX_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
				RX_TOGGLE: out_stall <= ~out_stall;
				default:   out_stall <= 1'b1;
			endcase
		end
	end

	// Check each accepted result against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_checked++;
			if (expected_results.size() == 0) begin
				$display("[%0t] unexpected result: expected none, got char=%h cv=%b rl=%b end=%b err=%b",
					$time, out_char, char_valid, run_last, expression_end, error);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				check_field("out_char", want.ch, out_char);
				check_field("char_valid", want.cv, char_valid);
				check_field("run_last", want.rl, run_last);
				check_field("expression_end", want.eoe, expression_end);
				check_field("error", want.err, error);
			end
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[%0t] timeout after %0d cycles, %0d items left, %0d results pending",
				$time, cycle_count, stim_q.size(), expected_results.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin : main
		int random_start;
		int pick;
		int nest;
		int pos;

		// Hand-picked rows: operand extremes, every operator, error cases
		intro_rows = '{
			'{8'h00,       1'b0, CHK_ECHO,        1'b0},
			'{8'hFF,       1'b1, CHK_ECHO_STATUS, 1'b0},
			'{CHAR_RPAREN, 1'b1, CHK_STATUS,      1'b1},
			'{"a",         1'b0, CHK_ECHO,        1'b0},
			'{CHAR_PLUS,   1'b0, CHK_NONE,        1'b0},
			'{"b",         1'b0, CHK_ECHO,        1'b0},
			'{CHAR_TIMES,  1'b0, CHK_NONE,        1'b0},
			'{"c",         1'b0, CHK_ECHO,        1'b0},
			'{CHAR_MINUS,  1'b0, CHK_MODEL,       1'b0},
			'{CHAR_LPAREN, 1'b0, CHK_NONE,        1'b0},
			'{"d",         1'b0, CHK_ECHO,        1'b0},
			'{CHAR_DIVIDE, 1'b0, CHK_NONE,        1'b0},
			'{"e",         1'b0, CHK_ECHO,        1'b0},
			'{CHAR_RPAREN, 1'b0, CHK_MODEL,       1'b0},
			'{"f",         1'b1, CHK_MODEL,       1'b0},
			'{CHAR_LPAREN, 1'b0, CHK_NONE,        1'b0},
			'{"g",         1'b1, CHK_MODEL,       1'b0},
			'{"h",         1'b0, CHK_ECHO,        1'b0},
			'{CHAR_PLUS,   1'b0, CHK_NONE,        1'b0},
			'{CHAR_RPAREN, 1'b0, CHK_MODEL,       1'b0},
			'{8'h80,       1'b1, CHK_MODEL,       1'b0},
			'{"x",         1'b0, CHK_ECHO,        1'b0},
			'{CHAR_DIVIDE, 1'b1, CHK_MODEL,       1'b0},
			'{CHAR_LPAREN, 1'b1, CHK_MODEL,       1'b0}
		};
		foreach (intro_rows[i])
			stim_q.push_back(intro_rows[i]);

		// Overflow the stack, then flush it whole on the closing operand
		repeat (STACK_DEPTH + 1)
			queue_item(CHAR_LPAREN, 1'b0);
		queue_item("z", 1'b1);

		// Random expressions: mostly well-formed, some broken, some noise
		random_start = stim_q.size();
		while (stim_q.size() - random_start < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 68) begin
				build_expression($urandom_range(0, 4));
				queue_expression();
			end else if (pick < 80) begin
				build_expression($urandom_range(1, 3));
				pos = $urandom_range(0, expr_buf.size() - 1);
				case ($urandom_range(0, 2))
					0: expr_buf.insert(pos, CHAR_LPAREN);
					1: expr_buf.insert(pos, CHAR_RPAREN);
					default: if (expr_buf.size() > 1) expr_buf.delete(pos);
				endcase
				queue_expression();
			end else if (pick < 95) begin
				repeat ($urandom_range(1, 8)) begin
					if ($urandom_range(0, 1) == 1)
						queue_item(pick_symbol($urandom_range(0, 5)), $urandom_range(0, 4) == 0);
					else
						queue_item(8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0);
				end
			end else begin
				// Nest around the stack depth, close some, end on an operand
				nest = $urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 3);
				repeat (nest) begin
					queue_item(CHAR_LPAREN, 1'b0);
					if ($urandom_range(0, 5) == 0)
						queue_item(random_operand(), 1'b0);
				end
				queue_item(random_operand(), 1'b0);
				repeat ($urandom_range(0, nest))
					queue_item(CHAR_RPAREN, 1'b0);
				queue_item(random_operand(), 1'b1);
			end
		end

		// Reset once, then let the channels run
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (stim_q.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d infix characters and %0d postfix items in %0d cycles.",
			items_taken, results_checked, cycle_count);
		$display("%0d expressions closed, %0d flagged; deepest stack %0d, longest run %0d.",
			exprs_closed, exprs_flagged, deepest, longest_run);
		if (fail_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
